// ===== hdl/lcbl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbl_pkg
// Shared types and constants of the light contribution blender: channel
// widths, input command codes, configuration indexes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcbl_pkg;

  // colour channel in q12, 4096 is full intensity
  localparam int unsigned CH_W     = 13;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PROD_W   = 2 * CH_W;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned MASK_W   = 8;

  localparam logic [CH_W-1:0] Q12_ONE = 13'd4096;

  // channel order inside an rgb vector
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // input item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // configuration register indexes
  localparam logic CFG_LIGHT_SPEED = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  // configuration reset values
  localparam logic [CH_W-1:0] LIGHT_SPEED_RST = 13'd130;
  localparam logic [CH_W-1:0] THRESHOLD_RST   = 13'd410;

  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DECIDE,
    ST_BL_CHECK,
    ST_BL_MUL,
    ST_BL_DIV,
    ST_BL_WAIT,
    ST_COMMIT,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic              load;       // store one contribution
    logic              capture;    // latch an evaluate beat
    logic              sum_acc;    // add one contributor slot
    logic [SLOT_W-1:0] idx;        // slot being summed
    logic              commit;     // take the summed colour as new target
    logic              freeze;     // with commit: current takes the blended colour
    logic              res_cur;    // result is the current colour
    logic              res_snap;   // snap to target
    logic              keep;       // snap keeps the interpolation running
    logic              mul;        // form |delta| * elapsed for one channel
    logic              div_start;  // start the divide by light speed
    logic              res_wr;     // write one interpolated channel
    logic [1:0]        ch;         // channel being interpolated
    logic              out_load;   // move the result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mask_zero;
    logic moved;
    logic lerp;
    logic snap;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/lcbl_div.sv =====
// ----------------------------------------------------------------------------
// lcbl_div
// Restoring divider, one quotient bit per cycle. The dividend is known to
// give a quotient below 2^13, so the upper half starts as the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lcbl_pkg::PROD_W-1:0]   dividend_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]     divisor_i,
  output logic      [lcbl_pkg::CH_W-1:0]     quot_o,
  output logic                               done_o
);

  localparam int unsigned W      = lcbl_pkg::CH_W;
  localparam int unsigned STEP_W = $clog2(W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      quot_q, quot_d;

  logic [W:0]        shifted;
  logic [W:0]        trial;
  logic              ge;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quot_q[W-1]};
    trial   = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = dividend_i[2*W-1:W];
      quot_d = dividend_i[W-1:0];
    end else if (busy_q) begin
      rem_d  = ge ? trial[W-1:0] : shifted[W-1:0];
      quot_d = {quot_q[W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/lcbl_dpath.sv =====
// ----------------------------------------------------------------------------
// lcbl_dpath
// Datapath of the light blender: configuration registers, contribution
// store, colour state, saturating summer, change test, shared multiplier
// and divider for the time interpolation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbl_dpath #(
  parameter int unsigned NUM_CONTRIBUTORS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lcbl_pkg::cmd_t                   cmd_i,
  output lcbl_pkg::status_t                     status_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]        cfg_data_i,
  // input beat payload
  input  wire logic [lcbl_pkg::SLOT_W-1:0]      contrib_index_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]        red_in_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]        green_in_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]        blue_in_i,
  input  wire logic [lcbl_pkg::MASK_W-1:0]      active_mask_i,
  input  wire logic [lcbl_pkg::TIME_W-1:0]      frame_time_i,
  input  wire logic [lcbl_pkg::TIME_W-1:0]      latest_update_time_i,
  // output beat payload
  output logic      [lcbl_pkg::CH_W-1:0]        red_out_o,
  output logic      [lcbl_pkg::CH_W-1:0]        green_out_o,
  output logic      [lcbl_pkg::CH_W-1:0]        blue_out_o
);

  localparam int unsigned W       = lcbl_pkg::CH_W;
  localparam int unsigned TW      = lcbl_pkg::TIME_W;
  localparam int unsigned SW      = lcbl_pkg::SLOT_W;
  localparam int unsigned IDX_W   = (NUM_CONTRIBUTORS > 1) ? $clog2(NUM_CONTRIBUTORS) : 1;
  localparam logic [lcbl_pkg::MASK_W-1:0] MASK_KEEP =
    lcbl_pkg::MASK_W'((16'd1 << NUM_CONTRIBUTORS) - 16'd1);

  function automatic logic [W-1:0] sat_q12(input logic [W-1:0] v);
    return (v > lcbl_pkg::Q12_ONE) ? lcbl_pkg::Q12_ONE : v;
  endfunction

  // configuration
  logic [W-1:0] ls_q;
  logic [W-1:0] thr_q;

  // block state
  lcbl_pkg::rgb_t store_q [NUM_CONTRIBUTORS];
  lcbl_pkg::rgb_t cur_q;
  lcbl_pkg::rgb_t tgt_q;
  logic [TW-1:0]  time_q;
  logic           lerp_q;

  // per-evaluate working registers
  logic [lcbl_pkg::MASK_W-1:0] mask_q;
  logic [TW-1:0]               now_q;
  logic [TW-1:0]               stamp_q;
  lcbl_pkg::rgb_t              sum_q, sum_d;
  lcbl_pkg::rgb_t              res_q;
  logic [lcbl_pkg::PROD_W-1:0] prod_q;
  logic                        neg_q;

  logic [TW-1:0]  elapsed;
  logic           snap;
  logic           moved;
  logic [W-1:0]   base_c;
  logic [W-1:0]   diff_c;
  logic [W:0]     acc_c;
  logic [IDX_W-1:0] sum_idx;
  logic [W-1:0]   cur_ch;
  logic [W-1:0]   tgt_ch;
  logic [W-1:0]   mag;
  logic [W-1:0]   quot;
  logic           div_done;
  logic           slot_ok;

  assign sum_idx = cmd_i.idx[IDX_W-1:0];
  assign slot_ok = {1'b0, contrib_index_i} < (SW + 1)'(NUM_CONTRIBUTORS);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q  <= lcbl_pkg::LIGHT_SPEED_RST;
      thr_q <= lcbl_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lcbl_pkg::CFG_LIGHT_SPEED) begin
        ls_q <= cfg_data_i;
      end else begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // elapsed time and snap test
  assign elapsed = now_q - time_q;
  assign snap    = (ls_q == '0) || (elapsed > TW'(ls_q));

  // saturating sum of one slot, and the change test against target or current
  always_comb begin
    sum_d  = sum_q;
    moved  = 1'b0;
    base_c = '0;
    diff_c = '0;
    acc_c  = '0;
    for (int c = 0; c < 3; c++) begin
      acc_c = {1'b0, sum_q[c]} + {1'b0, store_q[sum_idx][c]};
      if (mask_q[cmd_i.idx]) begin
        sum_d[c] = (acc_c > {1'b0, lcbl_pkg::Q12_ONE}) ? lcbl_pkg::Q12_ONE : acc_c[W-1:0];
      end
      base_c = lerp_q ? tgt_q[c] : cur_q[c];
      diff_c = (sum_q[c] > base_c) ? (sum_q[c] - base_c) : (base_c - sum_q[c]);
      if (diff_c >= thr_q) begin
        moved = 1'b1;
      end
    end
  end

  // channel selected for interpolation
  always_comb begin
    case (cmd_i.ch)
      lcbl_pkg::CH_RED: begin
        cur_ch = cur_q[0];
        tgt_ch = tgt_q[0];
      end
      lcbl_pkg::CH_GREEN: begin
        cur_ch = cur_q[1];
        tgt_ch = tgt_q[1];
      end
      lcbl_pkg::CH_BLUE: begin
        cur_ch = cur_q[2];
        tgt_ch = tgt_q[2];
      end
      default: begin
        cur_ch = '0;
        tgt_ch = '0;
      end
    endcase
    mag = (tgt_ch < cur_ch) ? (cur_ch - tgt_ch) : (tgt_ch - cur_ch);
  end

  // shared divide by light speed
  lcbl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (ls_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // colour state, contribution store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CONTRIBUTORS; i++) begin
        store_q[i] <= '0;
      end
      cur_q  <= '0;
      tgt_q  <= '0;
      time_q <= '0;
      lerp_q <= 1'b0;
    end else begin
      if (cmd_i.load && slot_ok) begin
        store_q[contrib_index_i[IDX_W-1:0]] <=
          {sat_q12(blue_in_i), sat_q12(green_in_i), sat_q12(red_in_i)};
      end
      if (cmd_i.commit) begin
        tgt_q  <= sum_q;
        time_q <= stamp_q;
        lerp_q <= 1'b1;
        if (cmd_i.freeze) begin
          cur_q <= res_q;
        end
      end
      if (cmd_i.res_snap) begin
        cur_q <= tgt_q;
        if (!cmd_i.keep) begin
          lerp_q <= 1'b0;
        end
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mask_q  <= active_mask_i & MASK_KEEP;
      now_q   <= frame_time_i;
      stamp_q <= latest_update_time_i;
      sum_q   <= '0;
    end
    if (cmd_i.sum_acc) begin
      sum_q <= sum_d;
    end
    if (cmd_i.res_cur) begin
      res_q <= cur_q;
    end
    if (cmd_i.res_snap) begin
      res_q <= tgt_q;
    end
    if (cmd_i.mul) begin
      prod_q <= lcbl_pkg::PROD_W'(mag) * lcbl_pkg::PROD_W'(elapsed[W-1:0]);
      neg_q  <= tgt_ch < cur_ch;
    end
    if (cmd_i.res_wr) begin
      res_q[cmd_i.ch] <= neg_q ? (cur_ch - quot) : (cur_ch + quot);
    end
    if (cmd_i.out_load) begin
      red_out_o   <= res_q[0];
      green_out_o <= res_q[1];
      blue_out_o  <= res_q[2];
    end
  end

  assign status_o.mask_zero = (mask_q == '0);
  assign status_o.moved     = moved;
  assign status_o.lerp      = lerp_q;
  assign status_o.snap      = snap;
  assign status_o.div_done  = div_done;

endmodule

`default_nettype wire

// ===== hdl/lcbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcbl_ctrl
// Controller of the light blender: sequences the contribution sum, the
// retarget decision, one or two interpolation passes and the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbl_ctrl #(
  parameter int unsigned NUM_CONTRIBUTORS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 cmd_i,
  input  wire logic                 any_changed_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lcbl_pkg::cmd_t            cmd_o,
  input  wire lcbl_pkg::status_t    status_i
);

  localparam int unsigned IDX_W = (NUM_CONTRIBUTORS > 1) ? $clog2(NUM_CONTRIBUTORS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CONTRIBUTORS - 1);

  lcbl_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [1:0]       ch_q, ch_d;
  logic             keep_q, keep_d;
  logic             out_valid_q, out_valid_d;
  lcbl_pkg::state_e after_blend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcbl_pkg::ST_IDLE;
      cnt_q       <= '0;
      ch_q        <= lcbl_pkg::CH_RED;
      keep_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ch_q        <= ch_d;
      keep_q      <= keep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ch_d        = ch_q;
    keep_d      = keep_q;
    out_valid_d = out_valid_q && out_stall_i;
    after_blend = keep_q ? lcbl_pkg::ST_COMMIT : lcbl_pkg::ST_OUT;

    cmd_o      = '0;
    cmd_o.idx  = lcbl_pkg::SLOT_W'(cnt_q);
    cmd_o.ch   = ch_q;
    cmd_o.keep = keep_q;

    case (state_q)
      lcbl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == lcbl_pkg::CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            cnt_d         = '0;
            keep_d        = 1'b0;
            state_d       = any_changed_i ? lcbl_pkg::ST_SUM : lcbl_pkg::ST_BL_CHECK;
          end
        end
      end
      lcbl_pkg::ST_SUM: begin
        cmd_o.sum_acc = 1'b1;
        if (cnt_q == IDX_LAST) begin
          state_d = lcbl_pkg::ST_DECIDE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lcbl_pkg::ST_DECIDE: begin
        // a new target freezes the running interpolation first
        if (status_i.mask_zero || status_i.moved) begin
          if (status_i.lerp) begin
            keep_d = 1'b1;
          end else begin
            cmd_o.commit = 1'b1;
          end
        end
        state_d = lcbl_pkg::ST_BL_CHECK;
      end
      lcbl_pkg::ST_BL_CHECK: begin
        if (!status_i.lerp) begin
          cmd_o.res_cur = 1'b1;
          state_d       = after_blend;
        end else if (status_i.snap) begin
          cmd_o.res_snap = 1'b1;
          state_d        = after_blend;
        end else begin
          ch_d    = lcbl_pkg::CH_RED;
          state_d = lcbl_pkg::ST_BL_MUL;
        end
      end
      lcbl_pkg::ST_BL_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = lcbl_pkg::ST_BL_DIV;
      end
      lcbl_pkg::ST_BL_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = lcbl_pkg::ST_BL_WAIT;
      end
      lcbl_pkg::ST_BL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.res_wr = 1'b1;
          if (ch_q == lcbl_pkg::CH_BLUE) begin
            state_d = after_blend;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = lcbl_pkg::ST_BL_MUL;
          end
        end
      end
      lcbl_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.freeze = 1'b1;
        keep_d       = 1'b0;
        state_d      = lcbl_pkg::ST_BL_CHECK;
      end
      lcbl_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = lcbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcbl_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != lcbl_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/light_contribution_blend_lerp.sv =====
// ----------------------------------------------------------------------------
// light_contribution_blend_lerp
// Point light blender: up to eight stored RGB contributions, summed and
// clamped on change, with a timed interpolation from the current colour
// towards the target. Colours are unsigned q12, 4096 is full intensity.
// ----------------------------------------------------------------------------
// A load beat (cmd 0) writes one contributor slot and gives no output beat.
// An evaluate beat (cmd 1) gives one output beat. When any_changed is set,
// the slots are summed first, one per cycle. Each interpolation pass takes
// each of the three channels through the one shared multiplier and then the
// 13-step restoring divider by light_speed. A new target taken while an
// interpolation runs costs a second pass. A finished beat waits in the
// output register while the next input beat is taken; configuration must be
// written only while the block is idle, which the block itself does not
// enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module light_contribution_blend_lerp #(
  parameter int unsigned NUM_CONTRIBUTORS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]     cfg_data_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [lcbl_pkg::SLOT_W-1:0]   contrib_index_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]     red_in_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]     green_in_i,
  input  wire logic [lcbl_pkg::CH_W-1:0]     blue_in_i,
  input  wire logic [lcbl_pkg::MASK_W-1:0]   active_mask_i,
  input  wire logic                          any_changed_i,
  input  wire logic [lcbl_pkg::TIME_W-1:0]   frame_time_i,
  input  wire logic [lcbl_pkg::TIME_W-1:0]   latest_update_time_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lcbl_pkg::CH_W-1:0]     red_out_o,
  output logic      [lcbl_pkg::CH_W-1:0]     green_out_o,
  output logic      [lcbl_pkg::CH_W-1:0]     blue_out_o
);

  lcbl_pkg::cmd_t    cmd;
  lcbl_pkg::status_t status;

  // sequencing
  lcbl_ctrl #(
    .NUM_CONTRIBUTORS (NUM_CONTRIBUTORS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .any_changed_i (any_changed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // arithmetic and state
  lcbl_dpath #(
    .NUM_CONTRIBUTORS (NUM_CONTRIBUTORS)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .contrib_index_i      (contrib_index_i),
    .red_in_i             (red_in_i),
    .green_in_i           (green_in_i),
    .blue_in_i            (blue_in_i),
    .active_mask_i        (active_mask_i),
    .frame_time_i         (frame_time_i),
    .latest_update_time_i (latest_update_time_i),
    .red_out_o            (red_out_o),
    .green_out_o          (green_out_o),
    .blue_out_o           (blue_out_o)
  );

endmodule

`default_nettype wire
